FILE: rtl/core/npc_pkg.sv
package npc_pkg;

    // Default palette depth
    localparam int NPC_MAX_COLORS = 256;

    // Slots reachable by an 8-bit entry index
    localparam int NPC_INDEX_SLOTS = 256;

    localparam int NPC_COMP_W  = 8;
    localparam int NPC_INDEX_W = 8;
    localparam int NPC_SIZE_W  = 9;
    localparam int NPC_DIST_W  = 18;   // 3 * 255^2 = 195075 fits in 18 bits

    // Start value of the running best distance, above any real distance
    localparam logic [NPC_DIST_W-1:0] NPC_DIST_INIT = '1;

    // Size register value after reset
    localparam logic [NPC_SIZE_W-1:0] NPC_SIZE_RESET = 9'd256;

    // Command codes carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    // Token handed from cell to cell
    typedef struct packed {
        logic                   valid;
        logic                   cmd;
        logic [NPC_INDEX_W-1:0] idx;
        logic [NPC_COMP_W-1:0]  red;
        logic [NPC_COMP_W-1:0]  green;
        logic [NPC_COMP_W-1:0]  blue;
        logic [NPC_DIST_W-1:0]  best_dist;
        logic [NPC_INDEX_W-1:0] best_index;
        logic [3*NPC_COMP_W-1:0] best_color;  // red 23:16, green 15:8, blue 7:0
    } npc_token_t;

endpackage

FILE: rtl/core/npc_cell.sv
module npc_cell import npc_pkg::*; #(
    parameter int CELL_INDEX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,        // whole chain advances together
    input  logic       active,    // this slot lies within the palette size
    input  npc_token_t tok_in,
    output npc_token_t tok_out
);

    localparam logic [NPC_INDEX_W-1:0] MY_INDEX = NPC_INDEX_W'(CELL_INDEX);

    logic [3*NPC_COMP_W-1:0] entry_reg;
    npc_token_t              tok_reg;
    npc_token_t              tok_next;

    logic [NPC_COMP_W-1:0]   dr, dg, db;
    logic [2*NPC_COMP_W-1:0] sr, sg, sb;
    logic [NPC_DIST_W-1:0]   sq_dist;
    logic                    load_hit;

    // Squared distance between the passing pixel and the stored entry
    always_comb begin
        dr = (entry_reg[23:16] > tok_in.red)   ? entry_reg[23:16] - tok_in.red
                                               : tok_in.red - entry_reg[23:16];
        dg = (entry_reg[15:8] > tok_in.green)  ? entry_reg[15:8] - tok_in.green
                                               : tok_in.green - entry_reg[15:8];
        db = (entry_reg[7:0] > tok_in.blue)    ? entry_reg[7:0] - tok_in.blue
                                               : tok_in.blue - entry_reg[7:0];
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        sq_dist = NPC_DIST_W'(sr) + NPC_DIST_W'(sg) + NPC_DIST_W'(sb);
    end

    assign load_hit = tok_in.valid && (tok_in.cmd == CMD_LOAD) && (tok_in.idx == MY_INDEX);

    // Strict less-than keeps the lowest index on ties
    always_comb begin
        tok_next = tok_in;
        if (tok_in.cmd == CMD_MAP && active && sq_dist < tok_in.best_dist) begin
            tok_next.best_dist  = sq_dist;
            tok_next.best_index = MY_INDEX;
            tok_next.best_color = entry_reg;
        end
    end

    // Palette slot held by this cell
    always_ff @(posedge aclk) begin
        if (en && load_hit) begin
            entry_reg <= {tok_in.red, tok_in.green, tok_in.blue};
        end
    end

    // Token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (en) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/core/nearest_palette_color_unit.sv
// Pipeline: a map transaction passes through one register per palette cell and then the
// output register before it shows on m_tvalid, NUM_CELLS = min(MAX_COLORS, 256).
// Throughput: one transaction per cycle; the whole cell row stalls only while a
// result waits on m_tready. Load transactions ride the same row and give no result.
// Reset: aresetn (synchronous, active low) empties the row and sets palette_size to 256;
// palette contents are not cleared and must be loaded before they are searched.
module nearest_palette_color_unit import npc_pkg::*; #(
    parameter int MAX_COLORS = NPC_MAX_COLORS
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: palette_size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_index[7:0], red_in[15:8], green_in[23:16], blue_in[31:24]
    input  logic [0:0]  s_tuser,   // cmd[0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16], best_index[31:24]
);

    localparam int NUM_CELLS = (MAX_COLORS < NPC_INDEX_SLOTS) ? MAX_COLORS : NPC_INDEX_SLOTS;

    logic [NPC_SIZE_W-1:0] size_reg;
    logic [NPC_SIZE_W-1:0] size_eff;
    logic                  en;
    npc_token_t            chain [0:NUM_CELLS];
    logic                  m_valid_reg;
    logic [31:0]           m_data_reg;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= NPC_SIZE_RESET;
        end else if (cfg_valid) begin
            size_reg <= cfg_data;
        end
    end

    // Entries in use: zero counts as one, clamp to the cell count
    always_comb begin
        if (size_reg == '0) begin
            size_eff = NPC_SIZE_W'(1);
        end else if (size_reg > NPC_SIZE_W'(NUM_CELLS)) begin
            size_eff = NPC_SIZE_W'(NUM_CELLS);
        end else begin
            size_eff = size_reg;
        end
    end

    // Row advances whenever the output register can take a new value
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Token entering the first cell
    always_comb begin
        chain[0].valid      = s_tvalid;
        chain[0].cmd        = s_tuser[0];
        chain[0].idx        = s_tdata[7:0];
        chain[0].red        = s_tdata[15:8];
        chain[0].green      = s_tdata[23:16];
        chain[0].blue       = s_tdata[31:24];
        chain[0].best_dist  = NPC_DIST_INIT;
        chain[0].best_index = '0;
        chain[0].best_color = '0;
    end

    // Row of palette cells
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        npc_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .active  (NPC_SIZE_W'(i) < size_eff),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    // Output register: only map transactions produce a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= chain[NUM_CELLS].valid && (chain[NUM_CELLS].cmd == CMD_MAP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {chain[NUM_CELLS].best_index,
                           chain[NUM_CELLS].best_color[7:0],
                           chain[NUM_CELLS].best_color[15:8],
                           chain[NUM_CELLS].best_color[23:16]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
